// ===== rtl/dqm_pkg.sv =====
package dqm_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;

  // Flipping the sign bit maps signed order onto unsigned order.
  localparam logic [DATA_W-1:0] SIGN_MASK = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_MEDIAN     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/deque_with_median_select_unit.sv =====
// Double-ended store of up to DEPTH signed 32-bit words with a median query.
// Each input word carries one operation; each produces exactly one result
// word with the value, a status and the count after the operation. Pushes,
// refused operations and unknown codes are answered from the idle state;
// pops pass through a result state, since the value comes from a memory
// with a registered read. The median (the element at rank count/2 of the
// sorted contents) is found by a bitwise radix select: one pass over the
// store per result bit, counting matches with one shared masked compare.
// The memory is not cleared after reset; only written entries are ever
// read.
module deque_with_median_select_unit
  import dqm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            op,
  input  logic signed [DATA_W-1:0]   value_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   value_out,
  output logic [STATUS_W-1:0]        status,
  output logic [CNT_W-1:0]           count_out
);

  localparam logic [IDX_W:0]   DEPTH_I = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MED,
    S_MED_END,
    S_RESULT
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;

  // Median sweep registers.
  logic [IDX_W-1:0]  med_ptr;
  logic [IDX_W-1:0]  med_idx;
  logic              rd_vld;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] bitsel;
  logic [DATA_W-1:0] cand;
  logic [CNT_W-1:0]  rank;
  logic [CNT_W-1:0]  hits;
  logic              res_med;

  logic              accept;
  logic              out_free;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  back_wr;
  logic [IDX_W-1:0]  back_rd;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  logic [IDX_W-1:0]  ptr_inc;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  logic              match;
  logic [CNT_W-1:0]  hits_tot;
  logic [DATA_W-1:0] cand_next;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_I) begin
      s = s - DEPTH_I;
    end
    return s[IDX_W-1:0];
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);
  assign cnt_m1    = count - CNT_W'(1);
  assign back_wr   = wrap_add(front, count[IDX_W-1:0]);
  assign back_rd   = wrap_add(front, cnt_m1[IDX_W-1:0]);
  assign front_dec = (front == '0) ? LAST_I : front - IDX_W'(1);
  assign front_inc = (front == LAST_I) ? '0 : front + IDX_W'(1);
  assign ptr_inc   = (med_ptr == LAST_I) ? '0 : med_ptr + IDX_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = front_dec;
    re    = 1'b0;
    raddr = front;
    if (accept) begin
      case (op)
        OP_PUSH_FRONT: begin
          we    = !full;
          waddr = front_dec;
        end
        OP_PUSH_BACK: begin
          we    = !full;
          waddr = back_wr;
        end
        OP_POP_FRONT: begin
          re    = !empty;
          raddr = front;
        end
        OP_POP_BACK: begin
          re    = !empty;
          raddr = back_rd;
        end
        default: begin
        end
      endcase
    end else if (state == S_MED) begin
      re    = 1'b1;
      raddr = med_ptr;
    end
  end

  dqm_ram #(
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A word counts toward the current bit if its decided upper bits match
  // the candidate prefix and the bit under test is zero.
  assign match    = rd_vld && (((rdata ^ SIGN_MASK) & mask) == cand);
  assign hits_tot = hits + CNT_W'(match);
  assign cand_next = (rank < hits_tot) ? cand : (cand | bitsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= (state == S_MED);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_out <= '0;
            status    <= ST_OK;
            count_out <= count;
            out_valid <= 1'b1;
            res_med   <= 1'b0;
            case (op)
              OP_PUSH_FRONT: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  front     <= front_dec;
                  count     <= count + CNT_W'(1);
                  count_out <= count + CNT_W'(1);
                end
              end
              OP_PUSH_BACK: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  count     <= count + CNT_W'(1);
                  count_out <= count + CNT_W'(1);
                end
              end
              OP_POP_FRONT: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  front     <= front_inc;
                  count     <= cnt_m1;
                  out_valid <= 1'b0;
                  state     <= S_RESULT;
                end
              end
              OP_POP_BACK: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  count     <= cnt_m1;
                  out_valid <= 1'b0;
                  state     <= S_RESULT;
                end
              end
              OP_MEDIAN: begin
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  out_valid <= 1'b0;
                  res_med   <= 1'b1;
                  med_ptr   <= front;
                  med_idx   <= '0;
                  mask      <= SIGN_MASK;
                  bitsel    <= SIGN_MASK;
                  cand      <= '0;
                  rank      <= count >> 1;
                  hits      <= '0;
                  state     <= S_MED;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MED: begin
          hits    <= hits_tot;
          med_ptr <= ptr_inc;
          med_idx <= med_idx + IDX_W'(1);
          if (med_idx == cnt_m1[IDX_W-1:0]) begin
            state <= S_MED_END;
          end
        end
        S_MED_END: begin
          cand    <= cand_next;
          hits    <= '0;
          med_ptr <= front;
          med_idx <= '0;
          if (rank >= hits_tot) begin
            rank <= rank - hits_tot;
          end
          if (bitsel[0]) begin
            state <= S_RESULT;
          end else begin
            bitsel <= bitsel >> 1;
            mask   <= mask | (bitsel >> 1);
            state  <= S_MED;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            value_out <= res_med ? (cand ^ SIGN_MASK) : rdata;
            status    <= ST_OK;
            count_out <= count;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stored count exceeds depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count_out == DEPTH_C))
    else $error("full status with store not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count_out == '0 && value_out == '0))
    else $error("empty status with words stored or nonzero value");

  a_median_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_MEDIAN && !empty) |=> (!in_ready && !out_valid))
    else $error("median query did not hold off the input");
`endif

endmodule

// ===== rtl/dqm_ram.sv =====
module dqm_ram
  import dqm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
